@@ src/mif_pkg.sv @@
package mif_pkg;

  // Width of the value, the modulus and the result.
  localparam int WIDTH = 32;

  // Bits of a counter that walks over the WIDTH bit positions.
  localparam int CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GCD  = 6'b000010,
    S_RED  = 6'b000100,
    S_SQR  = 6'b001000,
    S_MUL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

endpackage

@@ src/modular_inverse_fermat_top.sv @@
// One transaction is in work at a time: a binary gcd of value and modulus, then the value
// mod modulus, then a square-and-multiply over the exponent modulus - 2, paced by the
// bit-serial modular multiplier. The next transaction is accepted in the cycle after the
// result is loaded at the earliest.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops out_valid_o.
module modular_inverse_fermat_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mif_pkg::word_t     value_i,
  input  mif_pkg::word_t     modulus_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mif_pkg::word_t     inverse_o,
  output logic               exists_o
);
  import mif_pkg::*;

  // Sequencer state and the result register's valid flag.
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Operands of the transaction in work.
  word_t m_q, m_d;          // modulus
  word_t v_q, v_d;          // value, shifted out MSB first during the reduction
  word_t e_q, e_d;          // exponent modulus - 2, shifted out MSB first
  word_t a_q, a_d;          // gcd operands
  word_t b_q, b_d;

  // Exponentiation datapath.
  word_t base_q, base_d;    // value mod modulus
  word_t acc_q, acc_d;      // running power
  word_t x_q, x_d;          // multiplier operand, consumed one bit per cycle
  word_t prod_q, prod_d;    // partial product, always below the modulus
  cnt_t  bit_cnt_q, bit_cnt_d;
  cnt_t  exp_cnt_q, exp_cnt_d;
  logic  ok_q, ok_d;

  // Result register.
  word_t inverse_q, inverse_d;
  logic  exists_q, exists_d;

  // Datapath signals.
  word_t              mul_y;
  logic [WIDTH+1:0]   mul_s;
  logic [WIDTH+2:0]   mul_d1, mul_d2;
  word_t              mul_next;
  logic [WIDTH:0]     red_r;
  logic [WIDTH+1:0]   red_diff;
  word_t              red_next;
  logic [WIDTH:0]     gcd_ab;
  word_t              gcd_ba;
  logic               bit_last, exp_last;
  logic               out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign inverse_o   = inverse_q;
  assign exists_o    = exists_q;

  assign bit_last = (bit_cnt_q == cnt_t'(WIDTH - 1));
  assign exp_last = (exp_cnt_q == cnt_t'(WIDTH - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // Interleaved modular multiplication, one multiplier bit per cycle:
  // prod = 2 * prod + bit * y, then bring it back below the modulus. The sum
  // stays below three times the modulus, so subtracting m or 2m is enough.
  always_comb begin
    mul_y    = (state_q == S_MUL) ? base_q : acc_q;
    mul_s    = {1'b0, prod_q, 1'b0} + {2'b00, (x_q[WIDTH-1] ? mul_y : '0)};
    mul_d1   = {1'b0, mul_s} - {3'b000, m_q};
    mul_d2   = {1'b0, mul_s} - {2'b00, m_q, 1'b0};
    if (!mul_d2[WIDTH+2]) begin
      mul_next = mul_d2[WIDTH-1:0];
    end else if (!mul_d1[WIDTH+2]) begin
      mul_next = mul_d1[WIDTH-1:0];
    end else begin
      mul_next = mul_s[WIDTH-1:0];
    end
  end

  // Value mod modulus, one value bit per cycle by shift and conditional subtract.
  always_comb begin
    red_r    = {base_q, v_q[WIDTH-1]};
    red_diff = {1'b0, red_r} - {2'b00, m_q};
    red_next = red_diff[WIDTH+1] ? red_r[WIDTH-1:0] : red_diff[WIDTH-1:0];
  end

  assign gcd_ab = {1'b0, a_q} - {1'b0, b_q};
  assign gcd_ba = b_q - a_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    m_d         = m_q;
    v_d         = v_q;
    e_d         = e_q;
    a_d         = a_q;
    b_d         = b_q;
    base_d      = base_q;
    acc_d       = acc_q;
    x_d         = x_q;
    prod_d      = prod_q;
    bit_cnt_d   = bit_cnt_q;
    exp_cnt_d   = exp_cnt_q;
    ok_d        = ok_q;
    inverse_d   = inverse_q;
    exists_d    = exists_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          m_d  = modulus_i;
          v_d  = value_i;
          e_d  = modulus_i - word_t'(2);
          a_d  = value_i;
          b_d  = modulus_i;
          ok_d = 1'b0;
          // A modulus of zero or one never has an inverse.
          if (modulus_i < word_t'(2)) begin
            acc_d   = '0;
            state_d = S_FIN;
          end else begin
            state_d = S_GCD;
          end
        end
      end

      // Binary gcd. The second operand never reaches zero, so the loop ends when the first
      // one does (or early on a common factor of two) and the gcd is then the second.
      S_GCD: begin
        if (a_q == '0) begin
          if (b_q == word_t'(1)) begin
            base_d    = '0;
            bit_cnt_d = '0;
            state_d   = S_RED;
          end else begin
            acc_d   = '0;
            state_d = S_FIN;
          end
        end else if (!a_q[0] && !b_q[0]) begin
          // A common factor of two: the gcd cannot be one.
          acc_d   = '0;
          state_d = S_FIN;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!gcd_ab[WIDTH]) begin
          a_d = {1'b0, gcd_ab[WIDTH-1:1]};
        end else begin
          b_d = {1'b0, gcd_ba[WIDTH-1:1]};
        end
      end

      S_RED: begin
        base_d    = red_next;
        v_d       = v_q << 1;
        bit_cnt_d = bit_cnt_q + cnt_t'(1);
        if (bit_last) begin
          acc_d     = word_t'(1);
          x_d       = word_t'(1);
          prod_d    = '0;
          bit_cnt_d = '0;
          exp_cnt_d = '0;
          ok_d      = 1'b1;
          state_d   = S_SQR;
        end
      end

      S_SQR, S_MUL: begin
        prod_d    = mul_next;
        x_d       = x_q << 1;
        bit_cnt_d = bit_cnt_q + cnt_t'(1);
        if (bit_last) begin
          acc_d     = mul_next;
          x_d       = mul_next;
          prod_d    = '0;
          bit_cnt_d = '0;
          if ((state_q == S_SQR) && e_q[WIDTH-1]) begin
            state_d = S_MUL;
          end else begin
            // This exponent bit is finished.
            e_d = e_q << 1;
            if (exp_last) begin
              state_d = S_FIN;
            end else begin
              exp_cnt_d = exp_cnt_q + cnt_t'(1);
              state_d   = S_SQR;
            end
          end
        end
      end

      S_FIN: begin
        // Wait here only while the previous result is still held.
        if (out_free) begin
          out_valid_d = 1'b1;
          inverse_d   = acc_q;
          exists_d    = ok_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      exp_cnt_q   <= '0;
      ok_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      exp_cnt_q   <= exp_cnt_d;
      ok_q        <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    v_q       <= v_d;
    e_q       <= e_d;
    a_q       <= a_d;
    b_q       <= b_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    x_q       <= x_d;
    prod_q    <= prod_d;
    inverse_q <= inverse_d;
    exists_q  <= exists_d;
  end

  // The partial product and the running power stay reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SQR) || (state_q == S_MUL)) |-> ((prod_q < m_q) && (acc_q < m_q)))
    else $error("modular product left unreduced");

  // The second gcd operand never reaches zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD) |-> (b_q != '0))
    else $error("gcd operand reached zero");

  // A result without an inverse carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !exists_o) |-> (inverse_o == '0))
    else $error("nonzero inverse reported without an inverse");

  // An accepted transaction goes to the gcd or straight to the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ((state_q == S_GCD) || (state_q == S_FIN)))
    else $error("accepted transaction took a wrong path");

  // A new result is only loaded when the previous one has left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && out_valid_q && out_stall_i) |=> (state_q == S_FIN))
    else $error("result overwritten while held");

endmodule
